// ===== rtl/tlpm_pkg.sv =====
// ============================================================================
// tlpm_pkg: shared types and constants of the three-level page map unit
// Field widths, request and status codes, controller states and the
// command and status groups between controller and datapath.
// ============================================================================
`timescale 1ns / 1ps

package tlpm_pkg;

    // Fixed widths of the channel fields.
    localparam int REQ_TYPE_W    = 2;
    localparam int FIRST_PAGE_W  = 27;
    localparam int PAGE_COUNT_W  = 28;
    localparam int SPAN_ID_W     = 16;
    localparam int STATUS_W      = 2;

    // Depth of the radix walk.
    localparam int LEVELS = 3;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_UNUSED = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_NODES = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ROOT_RD,
        S_ROOT_EVAL,
        S_MID_RD,
        S_MID_EVAL,
        S_LEAF_OP,
        S_LEAF_EVAL,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic latch;
        logic root_rd;
        logic root_eval;
        logic mid_rd;
        logic mid_eval;
        logic leaf_op;
        logic leaf_eval;
        logic next_page;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_type_t req;
        logic      range_bad;
        logic      root_ok;
        logic      mid_ok;
        logic      pool_full;
        logic      more_pages;
        logic      clear_last;
        logic      out_free;
    } sts_t;

endpackage

// ===== rtl/tlpm_if.sv =====
// ============================================================================
// tlpm_if: request and response channels of the page map unit
// Valid/ready channels; an item moves at a clock edge with both high.
// ============================================================================
`timescale 1ns / 1ps

interface tlpm_req_if import tlpm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [REQ_TYPE_W-1:0]    req_type;
    logic [FIRST_PAGE_W-1:0]  first_page;
    logic [PAGE_COUNT_W-1:0]  page_count;
    logic [SPAN_ID_W-1:0]     span_id;

    modport source (output valid, req_type, first_page, page_count, span_id,
                    input ready);
    modport sink   (input valid, req_type, first_page, page_count, span_id,
                    output ready);
endinterface

interface tlpm_rsp_if import tlpm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [SPAN_ID_W-1:0] found_span;

    modport source (output valid, status, found, found_span, input ready);
    modport sink   (input valid, status, found, found_span, output ready);
endinterface

// ===== rtl/tlpm_ctrl.sv =====
// ============================================================================
// tlpm_ctrl: sequencer of the page map unit
// Steps the datapath through the clearing pass and the per-page walk.
// ============================================================================
`timescale 1ns / 1ps

module tlpm_ctrl import tlpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.range_bad || sts.req == REQ_UNUSED)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_ROOT_RD;
                end
            end
            S_ROOT_RD:
            begin
                cmd.root_rd = 1'b1;
                state_next  = S_ROOT_EVAL;
            end
            S_ROOT_EVAL:
            begin
                cmd.root_eval = 1'b1;
                if (sts.req == REQ_INSERT)
                begin
                    state_next = (!sts.root_ok && sts.pool_full) ? S_FINISH : S_MID_RD;
                end
                else if (sts.root_ok)
                begin
                    state_next = S_MID_RD;
                end
                else if (sts.more_pages)
                begin
                    cmd.next_page = 1'b1;
                    state_next    = S_ROOT_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MID_RD:
            begin
                cmd.mid_rd = 1'b1;
                state_next = S_MID_EVAL;
            end
            S_MID_EVAL:
            begin
                cmd.mid_eval = 1'b1;
                if (sts.req == REQ_INSERT)
                begin
                    state_next = (!sts.mid_ok && sts.pool_full) ? S_FINISH : S_LEAF_OP;
                end
                else if (sts.mid_ok)
                begin
                    state_next = S_LEAF_OP;
                end
                else if (sts.more_pages)
                begin
                    cmd.next_page = 1'b1;
                    state_next    = S_ROOT_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LEAF_OP:
            begin
                cmd.leaf_op = 1'b1;
                if (sts.req == REQ_LOOKUP)
                begin
                    state_next = S_LEAF_EVAL;
                end
                else if (sts.more_pages)
                begin
                    cmd.next_page = 1'b1;
                    state_next    = S_ROOT_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LEAF_EVAL:
            begin
                cmd.leaf_eval = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tlpm_datapath.sv =====
// ============================================================================
// tlpm_datapath: tables, node allocator and result registers
// Holds the root table, the node pool memory, the free-node count and
// the output register; acts on commands from the sequencer.
// ============================================================================
`timescale 1ns / 1ps

module tlpm_datapath import tlpm_pkg::*;
#(
    parameter int INDEX_BITS   = 9,
    parameter int NODE_POOL    = 64,
    parameter int SPAN_ID_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [REQ_TYPE_W-1:0]    req_type,
    input  logic [FIRST_PAGE_W-1:0]  first_page,
    input  logic [PAGE_COUNT_W-1:0]  page_count,
    input  logic [SPAN_ID_W-1:0]     span_id,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [STATUS_W-1:0]      out_status,
    output logic                     out_found,
    output logic [SPAN_ID_W-1:0]     out_found_span
);

    localparam int PAGE_BITS   = LEVELS * INDEX_BITS;
    localparam int SUM_W       = PAGE_COUNT_W + 1;
    localparam int WIDE_W      = PAGE_BITS + SUM_W;
    localparam int FANOUT      = 1 << INDEX_BITS;
    localparam int REF_W       = $clog2(NODE_POOL + 1);
    localparam int ROW_W       = $clog2(NODE_POOL);
    localparam int NADDR_W     = ROW_W + INDEX_BITS;
    localparam int NODE_DEPTH  = NODE_POOL * FANOUT;
    localparam int ENTRY_W     = (REF_W > SPAN_ID_BITS) ? REF_W : SPAN_ID_BITS;
    localparam int IN_SPAN_W   = SPAN_ID_W + SPAN_ID_BITS;

    // A node reference k names pool row k-1.
    function automatic logic [ROW_W-1:0] row_of(input logic [REF_W-1:0] node_ref);
        logic [REF_W-1:0] dec;
        dec    = node_ref - REF_W'(1);
        row_of = dec[ROW_W-1:0];
    endfunction

    logic [REF_W-1:0]   root_mem [FANOUT];
    logic [ENTRY_W-1:0] node_mem [NODE_DEPTH];

    req_type_t               type_reg;
    logic [PAGE_BITS-1:0]    first_reg;
    logic [PAGE_BITS-1:0]    last_reg;
    logic [SPAN_ID_BITS-1:0] id_reg;
    logic                    range_bad_reg;
    logic                    page_sel_reg;
    logic [REF_W-1:0]        mid_reg;
    logic [REF_W-1:0]        leaf_reg;
    logic [REF_W-1:0]        free_reg;
    logic [NADDR_W-1:0]      clr_reg;
    logic [REF_W-1:0]        root_rd_reg;
    logic [ENTRY_W-1:0]      node_rd_reg;
    status_t                 res_status_reg;
    logic                    res_found_reg;
    logic [SPAN_ID_BITS-1:0] res_span_reg;
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic                    out_found_reg;
    logic [SPAN_ID_BITS-1:0] out_span_reg;

    // Request capture and range check. An unknown request is ignored, so it
    // is never rejected for its page fields.
    req_type_t               in_type;
    logic [WIDE_W-1:0]       first_wide;
    logic [WIDE_W-1:0]       last_wide;
    logic                    range_bad_next;
    logic [IN_SPAN_W-1:0]    in_span_wide;
    logic [IN_SPAN_W-1:0]    out_span_wide;

    always_comb
    begin
        in_type        = req_type_t'(req_type);
        first_wide     = WIDE_W'(first_page);
        last_wide      = first_wide + WIDE_W'(page_count) - WIDE_W'(1);
        range_bad_next = (in_type != REQ_UNUSED)
                       && (((first_wide >> PAGE_BITS) != '0)
                           || ((in_type == REQ_INSERT || in_type == REQ_REMOVE)
                               && (page_count == '0 || (last_wide >> PAGE_BITS) != '0)));
        in_span_wide   = IN_SPAN_W'(span_id);
        out_span_wide  = IN_SPAN_W'(out_span_reg);
    end

    // Walk of the current page.
    logic [PAGE_BITS-1:0]  page_cur;
    logic [INDEX_BITS-1:0] slot0;
    logic [INDEX_BITS-1:0] slot1;
    logic [INDEX_BITS-1:0] slot2;
    logic                  is_insert;
    logic                  root_ok;
    logic                  mid_ok;
    logic                  pool_full;
    logic [REF_W-1:0]      new_ref;
    logic [REF_W-1:0]      mid_ref;
    logic                  root_alloc;
    logic                  mid_alloc;
    logic                  alloc_fail;
    logic [ROW_W-1:0]      mid_row;
    logic [ROW_W-1:0]      leaf_row;

    always_comb
    begin
        page_cur   = page_sel_reg ? last_reg : first_reg;
        slot0      = page_cur[2*INDEX_BITS +: INDEX_BITS];
        slot1      = page_cur[INDEX_BITS +: INDEX_BITS];
        slot2      = page_cur[0 +: INDEX_BITS];
        is_insert  = (type_reg == REQ_INSERT);
        root_ok    = (root_rd_reg != '0) && (root_rd_reg <= REF_W'(NODE_POOL));
        mid_ok     = (node_rd_reg != '0) && (node_rd_reg <= ENTRY_W'(NODE_POOL));
        pool_full  = (free_reg == REF_W'(NODE_POOL));
        new_ref    = free_reg + REF_W'(1);
        mid_ref    = node_rd_reg[REF_W-1:0];
        root_alloc = cmd.root_eval && is_insert && !root_ok && !pool_full;
        mid_alloc  = cmd.mid_eval && is_insert && !mid_ok && !pool_full;
        alloc_fail = ((cmd.root_eval && !root_ok) || (cmd.mid_eval && !mid_ok))
                     && is_insert && pool_full;
        mid_row    = row_of(mid_reg);
        leaf_row   = row_of(leaf_reg);
    end

    // Single write port of each memory, shared by clearing and allocation and,
    // for the node pool, also by leaf updates; these never coincide.
    logic                  root_we;
    logic [INDEX_BITS-1:0] root_waddr;
    logic [REF_W-1:0]      root_wdata;
    logic                  node_we;
    logic [NADDR_W-1:0]    node_waddr;
    logic [ENTRY_W-1:0]    node_wdata;
    logic                  node_re;
    logic [NADDR_W-1:0]    node_raddr;

    always_comb
    begin
        root_we    = cmd.clear || root_alloc;
        root_waddr = cmd.clear ? clr_reg[INDEX_BITS-1:0] : slot0;
        root_wdata = cmd.clear ? '0 : new_ref;

        node_we    = 1'b0;
        node_waddr = clr_reg;
        node_wdata = '0;
        if (cmd.clear)
        begin
            node_we = 1'b1;
        end
        else if (mid_alloc)
        begin
            node_we    = 1'b1;
            node_waddr = {mid_row, slot1};
            node_wdata = ENTRY_W'(new_ref);
        end
        else if (cmd.leaf_op && type_reg != REQ_LOOKUP)
        begin
            node_we    = 1'b1;
            node_waddr = {leaf_row, slot2};
            node_wdata = is_insert ? ENTRY_W'(id_reg) : '0;
        end

        node_re    = cmd.mid_rd || (cmd.leaf_op && type_reg == REQ_LOOKUP);
        node_raddr = cmd.mid_rd ? {mid_row, slot1} : {leaf_row, slot2};
    end

    always_ff @(posedge clk)
    begin
        if (root_we)
        begin
            root_mem[root_waddr] <= root_wdata;
        end
        if (cmd.root_rd)
        begin
            root_rd_reg <= root_mem[slot0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rd_reg <= node_mem[node_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            type_reg      <= in_type;
            first_reg     <= first_wide[PAGE_BITS-1:0];
            last_reg      <= last_wide[PAGE_BITS-1:0];
            id_reg        <= in_span_wide[SPAN_ID_BITS-1:0];
            range_bad_reg <= range_bad_next;
        end
        if (cmd.root_eval)
        begin
            mid_reg <= root_ok ? root_rd_reg : new_ref;
        end
        if (cmd.mid_eval)
        begin
            leaf_reg <= mid_ok ? mid_ref : new_ref;
        end
        if (cmd.latch)
        begin
            res_status_reg <= range_bad_next ? ST_RANGE : ST_OK;
            res_found_reg  <= 1'b0;
            res_span_reg   <= '0;
        end
        else if (alloc_fail)
        begin
            res_status_reg <= ST_NO_NODES;
        end
        else if (cmd.leaf_eval)
        begin
            res_span_reg  <= node_rd_reg[SPAN_ID_BITS-1:0];
            res_found_reg <= (node_rd_reg[SPAN_ID_BITS-1:0] != '0);
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_span_reg   <= res_span_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= '0;
            clr_reg       <= '0;
            page_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (root_alloc || mid_alloc)
            begin
                free_reg <= new_ref;
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + NADDR_W'(1);
            end
            if (cmd.latch)
            begin
                page_sel_reg <= 1'b0;
            end
            else if (cmd.next_page)
            begin
                page_sel_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.req        = type_reg;
        sts.range_bad  = range_bad_reg;
        sts.root_ok    = root_ok;
        sts.mid_ok     = mid_ok;
        sts.pool_full  = pool_full;
        sts.more_pages = (type_reg == REQ_INSERT || type_reg == REQ_REMOVE) && !page_sel_reg;
        sts.clear_last = (clr_reg == NADDR_W'(NODE_DEPTH - 1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_found      = out_found_reg;
    assign out_found_span = out_span_wide[SPAN_ID_W-1:0];

    // The free count only ever grows by one node at a time.
    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (root_alloc || mid_alloc) |=> (free_reg == $past(free_reg) + REF_W'(1)))
        else $error("free node count did not advance by one on allocation");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= REF_W'(NODE_POOL))
        else $error("free node count ran past the pool size");

    // A leaf update needs a leaf node that exists.
    a_leaf_ref: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.leaf_op |-> (leaf_reg != '0 && leaf_reg <= REF_W'(NODE_POOL)))
        else $error("leaf access without a valid leaf node");

    // A result must never overwrite one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still pending");

endmodule

// ===== rtl/three_level_page_map_unit.sv =====
// ============================================================================
// three_level_page_map_unit: page number to span id radix map
// The walk of a page stops early when a node on it is missing on a lookup or
// remove, or when the pool runs out on insert; a rejected or unknown request
// goes from the range check straight to the result. The next item is taken
// in the cycle after the result is loaded; a result is not loaded while an
// earlier one still waits for the consumer. After reset a clearing pass
// zeroes both tables; no item is accepted until it ends.
// ============================================================================
`timescale 1ns / 1ps

module three_level_page_map_unit import tlpm_pkg::*;
#(
    parameter int INDEX_BITS   = 9,
    parameter int NODE_POOL    = 64,
    parameter int SPAN_ID_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    tlpm_req_if.sink       req,
    tlpm_rsp_if.source     rsp
);

    // The sequencer steps one item at a time: capture, range check, then
    // for each page of the request a root read, a middle-row read and a
    // leaf access, allocating nodes on insert as the walk finds them
    // missing. Insert and remove repeat the walk for the span's last page.
    // The result goes to an output register, so a new item may be taken
    // while the previous result still waits for the consumer.

    cmd_t cmd;
    sts_t sts;

    tlpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlpm_datapath #(
        .INDEX_BITS   (INDEX_BITS),
        .NODE_POOL    (NODE_POOL),
        .SPAN_ID_BITS (SPAN_ID_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_type       (req.req_type),
        .first_page     (req.first_page),
        .page_count     (req.page_count),
        .span_id        (req.span_id),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_status     (rsp.status),
        .out_found      (rsp.found),
        .out_found_span (rsp.found_span)
    );

endmodule
